/* rtl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer: command
// codes, configuration register indexes and the per-item result record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

   // Command codes carried by a request
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_START   = 3'd1,
      OP_STOP    = 3'd2,
      OP_ACK     = 3'd3,
      OP_NACK    = 3'd4,
      OP_WAITACK = 3'd5,
      OP_READ    = 3'd6,
      OP_WRITE   = 3'd7
   } op_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LONG_PHASE   = 2'd0,
      CSR_SHORT_PHASE  = 2'd1,
      CSR_SAMPLE_DELAY = 2'd2,
      CSR_ACK_TIMEOUT  = 2'd3
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [CSR_DATA_WIDTH-1:0] LONG_PHASE_RESET   = 16'd2000;
   localparam logic [CSR_DATA_WIDTH-1:0] SHORT_PHASE_RESET  = 16'd1000;
   localparam logic [CSR_DATA_WIDTH-1:0] SAMPLE_DELAY_RESET = 16'd10;
   localparam logic [CSR_DATA_WIDTH-1:0] ACK_TIMEOUT_RESET  = 16'd500;

   // Number of data bits in one byte transfer
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Result of one request
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive_enable;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_timed_out;
      logic       rejected;
   } res_type;

endpackage : i2cms_pkg

`default_nettype wire

/* rtl/i2cms_ctl.sv */
// ----------------------------------------------------------------------------
// i2cms_ctl
// Bus sequencer state, configuration registers and the single-pass
// next-state logic. The result of the presented request is computed
// combinationally; the state advances when step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ctl #(
   parameter int unsigned COUNTER_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [i2cms_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [i2cms_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  wire logic                                   step_en,
   input  wire logic [2:0]                             op,
   input  wire logic [7:0]                             tx_byte,
   input  wire logic                                   sda_in,
   output i2cms_pkg::res_type                          res
);

   import i2cms_pkg::*;

   localparam int unsigned CW = COUNTER_WIDTH;

   // Configuration registers
   logic [CSR_DATA_WIDTH-1:0] long_phase_ff, short_phase_ff, sample_delay_ff, ack_limit_ff;

   // Sequencer state
   op_type        cmd_ff, cmd_in;
   logic [2:0]    step_ff, step_in;
   logic [CW-1:0] phase_cnt_ff, phase_cnt_in;
   logic [CW-1:0] phase_len_ff, phase_len_in;
   logic [CW-1:0] timeout_ff, timeout_in;
   logic [3:0]    bit_cnt_ff, bit_cnt_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    last_rx_ff, last_rx_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in_lvl;
   logic          oe_ff, oe_in;

   // Per-item strobes and scratch
   logic          do_enter;
   logic          finish;
   logic          timed;
   logic          rej;
   logic [CW-1:0] enter_len;
   logic [CW-1:0] pc_inc;
   op_type        op_cmd;

   // Phase lengths, truncated to the counter width; zero acts as one tick
   logic [CW-1:0] long_trunc, short_trunc, delay_trunc, limit_trunc;
   logic [CW-1:0] long_ticks, short_ticks, delay_ticks;

   assign long_trunc  = CW'(long_phase_ff);
   assign short_trunc = CW'(short_phase_ff);
   assign delay_trunc = CW'(sample_delay_ff);
   assign limit_trunc = CW'(ack_limit_ff);
   assign long_ticks  = (long_trunc  == '0) ? CW'(1) : long_trunc;
   assign short_ticks = (short_trunc == '0) ? CW'(1) : short_trunc;
   assign delay_ticks = (delay_trunc == '0) ? CW'(1) : delay_trunc;
   assign pc_inc      = phase_cnt_ff + CW'(1);
   assign op_cmd      = op_type'(op);

   // Compute the next state and the result of the presented request
   always_comb begin
      cmd_in       = cmd_ff;
      step_in      = step_ff;
      phase_cnt_in = phase_cnt_ff;
      phase_len_in = phase_len_ff;
      timeout_in   = timeout_ff;
      bit_cnt_in   = bit_cnt_ff;
      shift_in     = shift_ff;
      last_rx_in   = last_rx_ff;
      scl_in       = scl_ff;
      sda_in_lvl   = sda_ff;
      oe_in        = oe_ff;
      do_enter     = 1'b0;
      finish       = 1'b0;
      timed        = 1'b0;
      rej          = 1'b0;
      enter_len    = '0;

      // Take or reject a command, poll for ack, or count up the running phase
      if (op_cmd != OP_TICK) begin
         if (cmd_ff != OP_TICK) begin
            rej = 1'b1;
         end else begin
            cmd_in       = op_cmd;
            step_in      = 3'd0;
            phase_cnt_in = '0;
            bit_cnt_in   = 4'd0;
            timeout_in   = '0;
            shift_in     = (op_cmd == OP_WRITE) ? tx_byte : 8'h00;
            do_enter     = 1'b1;
         end
      end else if (cmd_ff == OP_WAITACK && step_ff == 3'd2) begin
         if (!sda_in) begin
            scl_in = 1'b0;
            finish = 1'b1;
         end else if (timeout_ff >= limit_trunc) begin
            step_in      = 3'd3;
            phase_cnt_in = '0;
            do_enter     = 1'b1;
         end else begin
            timeout_in = timeout_ff + CW'(1);
         end
      end else if (cmd_ff != OP_TICK) begin
         if (pc_inc >= phase_len_ff) begin
            phase_cnt_in = '0;
            step_in      = step_ff + 3'd1;
            do_enter     = 1'b1;
         end else begin
            phase_cnt_in = pc_inc;
         end
      end

      // Apply the entry actions of the new step
      if (do_enter) begin
         unique case (cmd_in)
            OP_START: begin
               if (step_in == 3'd0) begin
                  oe_in = 1'b1; scl_in = 1'b1; sda_in_lvl = 1'b1; enter_len = long_ticks;
               end else if (step_in == 3'd1) begin
                  sda_in_lvl = 1'b0; enter_len = long_ticks;
               end else begin
                  scl_in = 1'b0;
               end
            end
            OP_STOP: begin
               if (step_in == 3'd0) begin
                  oe_in = 1'b1; scl_in = 1'b0; sda_in_lvl = 1'b0; enter_len = long_ticks;
               end else if (step_in == 3'd1) begin
                  sda_in_lvl = 1'b1; scl_in = 1'b1; enter_len = long_ticks;
               end
            end
            OP_ACK, OP_NACK: begin
               if (step_in == 3'd0) begin
                  oe_in = 1'b1; scl_in = 1'b0;
                  sda_in_lvl = (cmd_in == OP_NACK);
                  enter_len = long_ticks;
               end else if (step_in == 3'd1) begin
                  scl_in = 1'b1; enter_len = long_ticks;
               end else begin
                  scl_in = 1'b0;
               end
            end
            OP_WAITACK: begin
               if (step_in == 3'd0) begin
                  oe_in = 1'b0; enter_len = long_ticks;
               end else if (step_in == 3'd1) begin
                  scl_in = 1'b1; enter_len = long_ticks;
               end else if (step_in == 3'd2) begin
                  timeout_in = '0; enter_len = CW'(1);
               end else if (step_in == 3'd3) begin
                  oe_in = 1'b1; scl_in = 1'b0; sda_in_lvl = 1'b0; enter_len = long_ticks;
               end else if (step_in == 3'd4) begin
                  sda_in_lvl = 1'b1; scl_in = 1'b1; enter_len = long_ticks;
               end else begin
                  timed = 1'b1;
               end
            end
            OP_READ: begin
               if (step_in == 3'd0) begin
                  oe_in = 1'b0; enter_len = short_ticks;
               end else if (step_in == 3'd1) begin
                  scl_in = 1'b0; enter_len = short_ticks;
               end else if (step_in == 3'd2) begin
                  scl_in = 1'b1; enter_len = delay_ticks;
               end else if (step_in == 3'd3) begin
                  shift_in   = {shift_in[6:0], sda_in};
                  bit_cnt_in = bit_cnt_in + 4'd1;
                  if (bit_cnt_in < BITS_PER_BYTE) begin
                     step_in = 3'd0; enter_len = short_ticks;
                  end else begin
                     enter_len = long_ticks;
                  end
               end else begin
                  last_rx_in = shift_in;
               end
            end
            OP_WRITE: begin
               if (step_in == 3'd0) begin
                  oe_in = 1'b1; scl_in = 1'b0; enter_len = short_ticks;
               end else if (step_in == 3'd1) begin
                  sda_in_lvl = shift_in[7];
                  shift_in   = {shift_in[6:0], 1'b0};
                  enter_len  = short_ticks;
               end else if (step_in == 3'd2) begin
                  scl_in = 1'b1; enter_len = short_ticks;
               end else if (step_in == 3'd3) begin
                  scl_in = 1'b0; bit_cnt_in = bit_cnt_in + 4'd1; enter_len = short_ticks;
               end else if (bit_cnt_in < BITS_PER_BYTE) begin
                  step_in    = 3'd1;
                  sda_in_lvl = shift_in[7];
                  shift_in   = {shift_in[6:0], 1'b0};
                  enter_len  = short_ticks;
               end
            end
            default: begin
               enter_len = '0;
            end
         endcase

         if (enter_len == '0) begin
            finish = 1'b1;
         end else begin
            phase_len_in = enter_len;
         end
      end

      // Drop back to idle when the sequence ends
      if (finish) begin
         cmd_in       = OP_TICK;
         step_in      = 3'd0;
         phase_cnt_in = '0;
         phase_len_in = '0;
      end
   end

   // Drive the result of the presented request
   assign res.scl_level        = scl_in;
   assign res.sda_level        = sda_in_lvl;
   assign res.sda_drive_enable = oe_in;
   assign res.busy_res         = (cmd_in != OP_TICK);
   assign res.done_res         = finish;
   assign res.rx_byte          = last_rx_in;
   assign res.ack_timed_out    = timed;
   assign res.rejected         = rej;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_phase_ff   <= LONG_PHASE_RESET;
         short_phase_ff  <= SHORT_PHASE_RESET;
         sample_delay_ff <= SAMPLE_DELAY_RESET;
         ack_limit_ff    <= ACK_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LONG_PHASE:   long_phase_ff   <= csr_write_data;
            CSR_SHORT_PHASE:  short_phase_ff  <= csr_write_data;
            CSR_SAMPLE_DELAY: sample_delay_ff <= csr_write_data;
            CSR_ACK_TIMEOUT:  ack_limit_ff    <= csr_write_data;
            default:          ack_limit_ff    <= ack_limit_ff;
         endcase
      end
   end

   // Advance the sequencer state once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= OP_TICK;
         step_ff      <= 3'd0;
         phase_cnt_ff <= '0;
         phase_len_ff <= '0;
         timeout_ff   <= '0;
         bit_cnt_ff   <= 4'd0;
         shift_ff     <= 8'h00;
         last_rx_ff   <= 8'h00;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         oe_ff        <= 1'b0;
      end else if (step_en) begin
         cmd_ff       <= cmd_in;
         step_ff      <= step_in;
         phase_cnt_ff <= phase_cnt_in;
         phase_len_ff <= phase_len_in;
         timeout_ff   <= timeout_in;
         bit_cnt_ff   <= bit_cnt_in;
         shift_ff     <= shift_in;
         last_rx_ff   <= last_rx_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in_lvl;
         oe_ff        <= oe_in;
      end
   end

endmodule : i2cms_ctl

`default_nettype wire

/* rtl/i2c_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master bit engine: commands and timing ticks in, bus drive levels
// and command status out, one result per request.
// ----------------------------------------------------------------------------
// Each request is a command (start, stop, ack, nack, wait-for-ack, read,
// write) or a tick carrying the sampled SDA level; each produces exactly one
// response with the SCL/SDA levels, SDA direction and status after it.
// Phases last a configured number of ticks. The block takes one request per
// clock while req_stall is low: a request passes an input register, one
// pass of next-state logic, and lands in the response register. The input
// register keeps accepting while a response is stalled, holding one more
// request before req_stall rises.
// Write the configuration registers only while no request is in flight.
`default_nettype none

module i2c_master_bit_sequencer #(
   parameter int unsigned COUNTER_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // configuration
   input  wire logic                                   csr_write_enable,
   input  wire logic [i2cms_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [i2cms_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [2:0]                             req_op,
   input  wire logic [7:0]                             req_tx_byte,
   input  wire logic                                   req_sda_in,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_scl_level,
   output logic                                        rsp_sda_level,
   output logic                                        rsp_sda_drive_enable,
   output logic                                        rsp_busy_res,
   output logic                                        rsp_done_res,
   output logic [7:0]                                  rsp_rx_byte,
   output logic                                        rsp_ack_timed_out,
   output logic                                        rsp_rejected
);

   import i2cms_pkg::*;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_op_ff;
   logic [7:0] in_tx_ff;
   logic       in_sda_ff;

   // Response register
   logic       out_valid_ff, out_valid_in;
   res_type    out_res_ff;
   res_type    step_res;

   logic       req_take;
   logic       advance;

   // Move the held request on when the response slot is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Run the sequencer on the held request
   i2cms_ctl #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_ctl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step_en          (advance),
      .op               (in_op_ff),
      .tx_byte          (in_tx_ff),
      .sda_in           (in_sda_ff),
      .res              (step_res)
   );

   // Next valid flags of both registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request and response payloads
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_op;
         in_tx_ff  <= req_tx_byte;
         in_sda_ff <= req_sda_in;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_scl_level        = out_res_ff.scl_level;
   assign rsp_sda_level        = out_res_ff.sda_level;
   assign rsp_sda_drive_enable = out_res_ff.sda_drive_enable;
   assign rsp_busy_res         = out_res_ff.busy_res;
   assign rsp_done_res         = out_res_ff.done_res;
   assign rsp_rx_byte          = out_res_ff.rx_byte;
   assign rsp_ack_timed_out    = out_res_ff.ack_timed_out;
   assign rsp_rejected         = out_res_ff.rejected;

endmodule : i2c_master_bit_sequencer

`default_nettype wire
